// ----- hdl/lkr_pkg.sv -----
// Package for the LRU-K frame replacer: sizes, command codes, payload and entry types.
`default_nettype none
package lkr_pkg;

   // Frame table geometry
   localparam int FRAME_COUNT = 64;
   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
   localparam int SCAN_W      = $clog2(FRAME_COUNT) + 1;
   localparam int STAMP_W     = 48;
   localparam int HIT_W       = 4;
   localparam int K_W         = 4;

   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(FRAME_COUNT);
   localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
   localparam logic [K_W-1:0]    K_MIN    = K_W'(2);

   // Command codes
   localparam logic [1:0] KIND_ACCESS = 2'd0;
   localparam logic [1:0] KIND_MARK   = 2'd1;
   localparam logic [1:0] KIND_EVICT  = 2'd2;
   localparam logic [1:0] KIND_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FRAME_W-1:0] frame_index;
      logic               make_evictable;
   } lkr_req_type;

   typedef struct packed {
      logic               victim_found;
      logic [FRAME_W-1:0] victim_frame;
      logic [CNT_W-1:0]   evictable_total;
      logic               op_error;
   } lkr_rsp_type;

   // One frame's stored state
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [HIT_W-1:0]   hit;
      logic               evict;
      logic               active;
   } lkr_entry_type;

   localparam lkr_entry_type ENTRY_RESET = '{stamp: '0, hit: '0, evict: 1'b1, active: 1'b0};

endpackage
`default_nettype wire

// ----- hdl/lru_k_frame_replacer.sv -----
// Top level of the LRU-K frame replacer: frame table memory, scan sequencer and counters.
//
//  channel | ports                                | direction | moves
//  req     | req_valid, req_stall, req_data       | in        | one command transaction
//  rsp     | rsp_valid, rsp_stall, rsp_data       | out       | one result transaction
//  csr     | csr_wr_en, csr_wr_data               | in        | K register write
//
//  Access, mark and remove do one frame table read, then the update write.
//  Evict runs a pipelined scan of all 64 frame entries through the
//  single read port and one 48-bit stamp comparator, then the commit; it goes straight
//  to the commit if nothing is evictable. A K write starts a recount scan with req_stall held high.
//  Reset clears per-frame valid bits, so no table clearing pass is needed.
//  A finished result waits in the rsp register; a later command is accepted meanwhile and
//  holds in its last step until the register frees.
`default_nettype none
module lru_k_frame_replacer
   import lkr_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire lkr_req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output lkr_rsp_type       rsp_data,
   input  wire               csr_wr_en,
   input  wire  [K_W-1:0]    csr_wr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_UPDATE, ST_SCAN, ST_DONE} state_type;

   // Frame table and its read stage
   lkr_entry_type           mem [FRAME_COUNT];
   lkr_entry_type           rd_data_ff;
   logic                    rd_vld_ff;
   logic [FRAME_W-1:0]      rd_idx_ff;
   logic [FRAME_COUNT-1:0]  vld_ff;

   state_type               state_ff, state_in;
   lkr_req_type             req_ff, req_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [STAMP_W-1:0]      ctr_ff, ctr_in;
   logic [CNT_W-1:0]        evc_ff, evc_in;
   logic [CNT_W-1:0]        hc_ff, hc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SCAN_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                    recount_ff, recount_in;
   logic                    have_ff, have_in;
   logic [STAMP_W-1:0]      best_ff, best_in;
   logic [FRAME_W-1:0]      pick_ff, pick_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lkr_rsp_type             rsp_ff, rsp_in;

   logic                    rd_en;
   logic [FRAME_W-1:0]      rd_addr;
   logic                    wr_en;
   logic                    vld_clr;
   logic [FRAME_W-1:0]      wr_addr;
   lkr_entry_type           wr_entry;
   lkr_entry_type           ent;
   logic [K_W-1:0]          k_eff;
   logic [HIT_W:0]          c_inc;
   logic [HIT_W:0]          k_ext;
   logic                    slot_free;
   logic                    req_take;
   logic                    live;
   logic                    in_hist;
   logic                    tracked;
   logic                    prev_ev;
   logic                    cur_ev;

   assign k_eff     = (k_ff < K_MIN) ? K_MIN : k_ff;
   assign ent       = rd_vld_ff ? rd_data_ff : ENTRY_RESET;
   assign c_inc     = {1'b0, ent.hit} + (HIT_W+1)'(1);
   assign k_ext     = {1'b0, k_eff};
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || csr_wr_en;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next-state logic of the sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      k_in         = k_ff;
      ctr_in       = ctr_ff;
      evc_in       = evc_ff;
      hc_in        = hc_ff;
      cnt_in       = cnt_ff;
      scan_idx_in  = scan_idx_ff;
      recount_in   = recount_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = req_ff.frame_index;
      wr_en        = 1'b0;
      vld_clr      = 1'b0;
      wr_addr      = req_ff.frame_index;
      wr_entry     = ent;
      live         = ent.active && ent.evict && (ent.hit != '0);
      in_hist      = ent.hit < k_eff;
      tracked      = ent.active && (ent.hit != '0);
      prev_ev      = tracked && ent.evict;
      cur_ev       = tracked && req_ff.make_evictable;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in  = req_data;
               have_in = 1'b0;
               if (req_data.kind == KIND_EVICT) begin
                  if (evc_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in    = ST_SCAN;
                     recount_in  = 1'b0;
                     scan_idx_in = '0;
                  end
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_data.frame_index;
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            if (slot_free) begin
               rsp_in = '{victim_found: 1'b0, victim_frame: '0, evictable_total: '0,
                          op_error: 1'b0};
               case (req_ff.kind)
                  KIND_ACCESS: begin
                     wr_en           = 1'b1;
                     wr_entry.active = 1'b1;
                     wr_entry.hit    = (ent.hit == HIT_MAX) ? ent.hit : c_inc[HIT_W-1:0];
                     if (ent.hit == '0) begin
                        wr_entry.stamp = ctr_ff;
                        ctr_in         = ctr_ff + STAMP_W'(1);
                        if (ent.evict) begin
                           evc_in = evc_ff + CNT_W'(1);
                           hc_in  = hc_ff + CNT_W'(1);
                        end
                     end else if (c_inc == k_ext) begin
                        // frame graduates to the cache queue
                        if (ent.evict && (hc_ff != '0)) begin
                           hc_in = hc_ff - CNT_W'(1);
                        end
                        wr_entry.stamp = ctr_ff;
                        ctr_in         = ctr_ff + STAMP_W'(1);
                     end else if (c_inc > k_ext) begin
                        wr_entry.stamp = ctr_ff;
                        ctr_in         = ctr_ff + STAMP_W'(1);
                     end
                  end
                  KIND_MARK: begin
                     wr_en          = 1'b1;
                     wr_entry.evict = req_ff.make_evictable;
                     if (!prev_ev && cur_ev) begin
                        evc_in = evc_ff + CNT_W'(1);
                        if (in_hist) begin
                           hc_in = hc_ff + CNT_W'(1);
                        end
                     end else if (prev_ev && !cur_ev) begin
                        if (evc_ff != '0) begin
                           evc_in = evc_ff - CNT_W'(1);
                        end
                        if (in_hist && (hc_ff != '0)) begin
                           hc_in = hc_ff - CNT_W'(1);
                        end
                     end
                  end
                  KIND_REMOVE: begin
                     if (ent.active) begin
                        if (!ent.evict) begin
                           rsp_in.op_error = 1'b1;
                        end else begin
                           if ((ent.hit != '0) && in_hist && (hc_ff != '0)) begin
                              hc_in = hc_ff - CNT_W'(1);
                           end
                           if ((ent.hit != '0) && (evc_ff != '0)) begin
                              evc_in = evc_ff - CNT_W'(1);
                           end
                           vld_clr = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.evictable_total = evc_in;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // read entry scan_idx while judging entry scan_idx-1
            rd_en       = scan_idx_ff < SCAN_END;
            rd_addr     = scan_idx_ff[FRAME_W-1:0];
            scan_idx_in = scan_idx_ff + SCAN_W'(1);
            if (scan_idx_ff != '0) begin
               if (recount_ff) begin
                  if (live && in_hist) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else if (live && (in_hist == (hc_ff != '0))) begin
                  if (!have_ff || (ent.stamp < best_ff)) begin
                     have_in = 1'b1;
                     best_in = ent.stamp;
                     pick_in = rd_idx_ff;
                  end
               end
            end
            if (scan_idx_ff == SCAN_END) begin
               if (recount_ff) begin
                  hc_in    = cnt_in;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               wr_addr = pick_ff;
               if (have_ff) begin
                  vld_clr = 1'b1;
                  evc_in  = evc_ff - CNT_W'(1);
                  if (hc_ff != '0) begin
                     hc_in = hc_ff - CNT_W'(1);
                  end
               end
               rsp_in = '{victim_found: have_ff,
                          victim_frame: have_ff ? pick_ff : '0,
                          evictable_total: evc_in,
                          op_error: 1'b0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // K write: store and recount the history queue
      if (csr_wr_en) begin
         k_in        = csr_wr_data;
         recount_in  = 1'b1;
         scan_idx_in = '0;
         cnt_in      = '0;
         state_in    = ST_SCAN;
      end
   end

   // State, counters, valid bits and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= K_MIN;
         ctr_ff       <= '0;
         evc_ff       <= '0;
         hc_ff        <= '0;
         cnt_ff       <= '0;
         scan_idx_ff  <= '0;
         recount_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         ctr_ff       <= ctr_in;
         evc_ff       <= evc_in;
         hc_ff        <= hc_in;
         cnt_ff       <= cnt_in;
         scan_idx_ff  <= scan_idx_in;
         recount_ff   <= recount_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (vld_clr) begin
            vld_ff[wr_addr] <= 1'b0;
         end
      end
      req_ff  <= req_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      rsp_ff  <= rsp_in;
   end

   // Frame table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

`ifndef SYNTHESIS
   // history evictable frames are a subset of all evictable frames
   a_hist_subset: assert property (@(posedge clock) disable iff (reset)
      hc_ff <= evc_ff)
      else $error("history count exceeds evictable count");

   a_evc_range: assert property (@(posedge clock) disable iff (reset)
      evc_ff <= CNT_W'(FRAME_COUNT))
      else $error("evictable count out of range");

   // an accepted command always leaves idle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after accepting a command");

   // results only come from the update or commit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE || $past(state_ff) == ST_DONE))
      else $error("result produced from an unexpected state");
`endif

endmodule
`default_nettype wire

// ----- dv/lru_k_frame_replacer_tb.sv -----
// Testbench for lru_k_frame_replacer: directed command table and predictor-checked traffic.
module lru_k_frame_replacer_tb
   import lkr_pkg::*;
();

   localparam int QUIET_LIMIT = 5000;
   localparam int CHUNK_ITEMS = 250;
   localparam int TAIL_CYCLES = 80;

   // A result typed in by hand; when pinned is low the predictor supplies it
   typedef struct packed {
      logic        pinned;
      lkr_rsp_type value;
   } pinned_result_type;

   typedef struct packed {
      lkr_req_type       cmd;
      pinned_result_type pin;
   } directed_row_type;

   // Directed commands, starting from reset with K = 2
   localparam directed_row_type DIRECTED_ROWS [0:22] = '{
      '{'{KIND_EVICT,  6'd0,  1'b0}, '{1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}}},
      '{'{KIND_REMOVE, 6'd5,  1'b0}, '{1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}}},
      '{'{KIND_MARK,   6'd63, 1'b0}, '{1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}}},
      '{'{KIND_ACCESS, 6'd0,  1'b0}, '{1'b1, '{1'b0, 6'd0, 7'd1, 1'b0}}},
      '{'{KIND_ACCESS, 6'd63, 1'b1}, '{1'b1, '{1'b0, 6'd0, 7'd1, 1'b0}}},
      '{'{KIND_REMOVE, 6'd63, 1'b0}, '{1'b1, '{1'b0, 6'd0, 7'd1, 1'b1}}},
      '{'{KIND_ACCESS, 6'd0,  1'b0}, '0},
      '{'{KIND_ACCESS, 6'd42, 1'b0}, '0},
      '{'{KIND_ACCESS, 6'd21, 1'b1}, '0},
      '{'{KIND_MARK,   6'd21, 1'b0}, '0},
      '{'{KIND_EVICT,  6'd0,  1'b0}, '0},
      '{'{KIND_MARK,   6'd63, 1'b1}, '0},
      '{'{KIND_EVICT,  6'd0,  1'b0}, '0},
      '{'{KIND_EVICT,  6'd0,  1'b0}, '0},
      '{'{KIND_EVICT,  6'd0,  1'b0}, '0},
      '{'{KIND_REMOVE, 6'd21, 1'b0}, '0},
      '{'{KIND_MARK,   6'd21, 1'b1}, '0},
      '{'{KIND_REMOVE, 6'd21, 1'b0}, '0},
      '{'{KIND_ACCESS, 6'd7,  1'b0}, '0},
      '{'{KIND_ACCESS, 6'd7,  1'b0}, '0},
      '{'{KIND_REMOVE, 6'd7,  1'b0}, '0},
      '{'{KIND_MARK,   6'd7,  1'b1}, '0},
      '{'{KIND_EVICT,  6'd0,  1'b0}, '0}
   };

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   lkr_req_type    req_data;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   lkr_rsp_type    rsp_data;
   logic           csr_wr_en;
   logic [K_W-1:0] csr_wr_data;

   int send_idle_pct  = 28;
   int recv_stall_pct = 78;
   int failures       = 0;

   pinned_result_type pinned_results [$];
   lkr_rsp_type       awaited_results [$];

   // Predictor copy of the frame table and counters
   logic [HIT_W-1:0]   hits_model   [FRAME_COUNT];
   logic               evict_model  [FRAME_COUNT];
   logic               active_model [FRAME_COUNT];
   logic [STAMP_W-1:0] stamp_model  [FRAME_COUNT];
   logic [STAMP_W-1:0] next_stamp;
   logic [K_W-1:0]     k_reg;
   int unsigned        evictable_cnt;
   int unsigned        hist_evictable_cnt;

   lru_k_frame_replacer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void reset_model();
      for (int i = 0; i < FRAME_COUNT; i++) begin
         hits_model[i]   = '0;
         evict_model[i]  = 1'b1;
         active_model[i] = 1'b0;
         stamp_model[i]  = '0;
      end
      next_stamp         = '0;
      k_reg              = K_W'(2);
      evictable_cnt      = 0;
      hist_evictable_cnt = 0;
   endfunction

   // K below the minimum behaves as the minimum
   function automatic int unsigned k_effective();
      return 32'((k_reg < K_MIN) ? K_MIN : k_reg);
   endfunction

   function automatic void recount_history();
      int unsigned k;
      k = k_effective();
      hist_evictable_cnt = 0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         if (active_model[i] && evict_model[i] && hits_model[i] != 0 && hits_model[i] < k)
            hist_evictable_cnt++;
      end
   endfunction

   function automatic logic [STAMP_W-1:0] take_stamp();
      logic [STAMP_W-1:0] s;
      s          = next_stamp;
      next_stamp = next_stamp + STAMP_W'(1);
      return s;
   endfunction

   function automatic void clear_entry(int unsigned f);
      active_model[f] = 1'b0;
      hits_model[f]   = '0;
      evict_model[f]  = 1'b1;
      stamp_model[f]  = '0;
   endfunction

   // Applies one command to the predictor state and returns the result it should produce
   function automatic lkr_rsp_type replace_outcome(lkr_req_type cmd);
      lkr_rsp_type        res;
      int unsigned        f, k, c, pick;
      bit                 tracked, was_ev, now_ev, in_hist, from_hist, have;
      logic [STAMP_W-1:0] best;
      res  = '0;
      f    = 32'(cmd.frame_index);
      k    = k_effective();
      have = 1'b0;
      best = '0;
      pick = 0;
      case (cmd.kind)
         KIND_ACCESS: begin
            c = 32'(hits_model[f]);
            active_model[f] = 1'b1;
            hits_model[f]   = (c < HIT_MAX) ? HIT_W'(c + 1) : HIT_MAX;
            if (c == 0) begin
               // first touch: join the history queue
               stamp_model[f] = take_stamp();
               if (evict_model[f]) begin
                  evictable_cnt++;
                  hist_evictable_cnt++;
               end
            end else if (c + 1 == k) begin
               // promotion to the cache queue
               if (evict_model[f] && hist_evictable_cnt > 0) hist_evictable_cnt--;
               stamp_model[f] = take_stamp();
            end else if (c + 1 > k) begin
               stamp_model[f] = take_stamp();
            end
         end
         KIND_MARK: begin
            tracked        = active_model[f] && hits_model[f] != 0;
            was_ev         = tracked && evict_model[f];
            now_ev         = tracked && cmd.make_evictable;
            in_hist        = hits_model[f] < k;
            evict_model[f] = cmd.make_evictable;
            if (!was_ev && now_ev) begin
               evictable_cnt++;
               if (in_hist) hist_evictable_cnt++;
            end else if (was_ev && !now_ev) begin
               if (evictable_cnt > 0) evictable_cnt--;
               if (in_hist && hist_evictable_cnt > 0) hist_evictable_cnt--;
            end
         end
         KIND_EVICT: begin
            if (evictable_cnt > 0) begin
               from_hist = hist_evictable_cnt > 0;
               // oldest stamp wins, lowest index on a tie
               for (int i = 0; i < FRAME_COUNT; i++) begin
                  if (active_model[i] && evict_model[i] && hits_model[i] != 0 &&
                      ((hits_model[i] < k) == from_hist) &&
                      (!have || stamp_model[i] < best)) begin
                     have = 1'b1;
                     best = stamp_model[i];
                     pick = i;
                  end
               end
               if (have) begin
                  res.victim_found = 1'b1;
                  res.victim_frame = FRAME_W'(pick);
                  clear_entry(pick);
                  evictable_cnt--;
                  if (from_hist && hist_evictable_cnt > 0) hist_evictable_cnt--;
               end
            end
         end
         KIND_REMOVE: begin
            if (active_model[f]) begin
               if (!evict_model[f]) begin
                  res.op_error = 1'b1;
               end else begin
                  c = 32'(hits_model[f]);
                  if (c > 0 && c < k) begin
                     if (hist_evictable_cnt > 0) hist_evictable_cnt--;
                     if (evictable_cnt > 0) evictable_cnt--;
                  end else if (c >= k) begin
                     if (evictable_cnt > 0) evictable_cnt--;
                  end
                  clear_entry(f);
               end
            end
         end
      endcase
      res.evictable_total = CNT_W'(evictable_cnt);
      return res;
   endfunction

   function automatic void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      failures++;
   endfunction

   // Mostly a window of eight hot frames so counts climb and queues fill
   function automatic lkr_req_type random_command(int unsigned hot_base);
      lkr_req_type cmd;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)      cmd.kind = KIND_ACCESS;
      else if (pick < 68) cmd.kind = KIND_MARK;
      else if (pick < 84) cmd.kind = KIND_EVICT;
      else                cmd.kind = KIND_REMOVE;
      if ($urandom_range(99) < 75)
         cmd.frame_index = FRAME_W'(hot_base + $urandom_range(0, 7));
      else
         cmd.frame_index = FRAME_W'($urandom_range(0, FRAME_COUNT - 1));
      cmd.make_evictable = $urandom_range(99) < 60;
      return cmd;
   endfunction

   // Random result-side backpressure
   always @(posedge clock) begin
      rsp_stall <= $urandom_range(99) < recv_stall_pct;
   end

   // Monitor: check result transactions, track K writes, predict accepted commands
   always @(posedge clock) begin
      lkr_rsp_type       want;
      lkr_rsp_type       predicted;
      pinned_result_type pin;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result transaction with none expected: %h", $time, rsp_data);
               failures++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.victim_found !== want.victim_found)
                  report_mismatch("victim_found", want.victim_found, rsp_data.victim_found);
               if (rsp_data.victim_frame !== want.victim_frame)
                  report_mismatch("victim_frame", want.victim_frame, rsp_data.victim_frame);
               if (rsp_data.evictable_total !== want.evictable_total)
                  report_mismatch("evictable_total", want.evictable_total,
                                  rsp_data.evictable_total);
               if (rsp_data.op_error !== want.op_error)
                  report_mismatch("op_error", want.op_error, rsp_data.op_error);
            end
         end
         if (csr_wr_en) begin
            k_reg = csr_wr_data;
            recount_history();
         end
         if (req_valid && !req_stall) begin
            predicted = replace_outcome(req_data);
            pin = pinned_results.pop_front();
            awaited_results.push_back(pin.pinned ? pin.value : predicted);
         end
      end
   end

   // Watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_command(input lkr_req_type cmd, input pinned_result_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pinned_results.push_back(pin);
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every expected result has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0 || pinned_results.size() != 0);
   endtask

   task automatic write_k(input logic [K_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [K_W-1:0] k_plan [6];
      int unsigned    hot_base;
      reset_model();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pin);

      // K settings per random chunk: below minimum, maximum, below minimum, mid values, minimum
      k_plan = '{4'd0, 4'd15, 4'd1, K_W'($urandom_range(3, 14)), 4'd4, 4'd2};
      for (int chunk = 0; chunk < 6; chunk++) begin
         if (chunk == 2) begin
            send_idle_pct  = 78;
            recv_stall_pct = 28;
         end
         if (chunk == 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_k(k_plan[chunk]);
         hot_base = $urandom_range(0, FRAME_COUNT - 1);
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            if (chunk == 2 && n == CHUNK_ITEMS / 2) wait_drained();
            send_command(random_command(hot_base), '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
